[rtl/core/kwm_pkg.sv]
// kwm_pkg: shared constants, types and codes for the k-way sorted merge unit
// no dependencies; imported by kwm_min_tree and k_way_sorted_merge_unit
`timescale 1ns / 1ps

package kwm_pkg;

  localparam int LIST_COUNT = 8;
  localparam int LIST_DEPTH = 16;
  localparam int VALUE_BITS = 32;

  // fixed field widths of the item ports
  localparam int IDX_BITS  = 3;
  localparam int DATA_BITS = 32;

  localparam int LIST_BITS = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
  localparam int PTR_BITS  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_BITS  = $clog2(LIST_DEPTH + 1);

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [PTR_BITS-1:0]          ptr_t;
  typedef logic [CNT_BITS-1:0]          cnt_t;
  typedef logic [LIST_BITS-1:0]         lidx_t;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_PULL = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_LOADED  = 2'd0,
    ST_DROPPED = 2'd1,
    ST_MERGED  = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  // head of one list as seen by the compare tree
  typedef struct packed {
    logic   valid;
    value_t value;
  } head_t;

  // winner of the compare tree
  typedef struct packed {
    logic   found;
    lidx_t  idx;
    value_t value;
  } win_t;

endpackage

[rtl/core/k_way_sorted_merge_unit.sv]
// k_way_sorted_merge_unit: top level of the k-way sorted merge
// depends on kwm_pkg, kwm_ram and kwm_min_tree
`timescale 1ns / 1ps

// usage
//   command channel: an item (kind_i, list_index_i, element_value_i) is taken
//   at a rising edge with start_i high and busy_o low. busy_o stays low, so an
//   item can be issued every cycle.
//   load item: appends element_value_i to list list_index_i; a full list or a
//   list number beyond the list count drops the value (status dropped).
//   pull item: removes the smallest head over all non-empty lists, lowest list
//   number on ties, and returns it with its list number; status empty if none.
//   result channel: done_o is high for exactly one cycle with status_o,
//   merged_value_o and source_list_o; the receiver cannot hold results off.
//   result path: the input register is loaded at the accepting edge, then the
//   compare tree and state update feed the result register, which drives the
//   result channel.
//   throughput: one item per cycle; each list keeps its head visible through a
//   per-list ram read every cycle at the next read pointer, plus a bypass
//   register for a value loaded into an empty list.
//   reset: rst_ni low clears all pointers and fill counts, so every list is
//   empty; ram contents are not cleared and need no clearing pass.

module k_way_sorted_merge_unit import kwm_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        kind_i,
  input  logic [IDX_BITS-1:0]         list_index_i,
  input  logic signed [DATA_BITS-1:0] element_value_i,
  output logic                        done_o,
  output logic [1:0]                  status_o,
  output logic signed [DATA_BITS-1:0] merged_value_o,
  output logic [IDX_BITS-1:0]         source_list_o
);

  // input register
  logic                        in_v_q;
  kind_e                       kind_q;
  logic [IDX_BITS-1:0]         idx_q;
  logic signed [DATA_BITS-1:0] val_q;

  // per-list control state
  ptr_t rd_ptr_q [LIST_COUNT];
  ptr_t rd_ptr_d [LIST_COUNT];
  ptr_t wr_ptr_q [LIST_COUNT];
  ptr_t wr_ptr_d [LIST_COUNT];
  cnt_t cnt_q    [LIST_COUNT];
  cnt_t cnt_d    [LIST_COUNT];

  // bypass for a value loaded into an empty list (the registered ram read lags the write)
  logic [LIST_COUNT-1:0] byp_sel_q;
  logic [LIST_COUNT-1:0] byp_sel_d;
  value_t                byp_q [LIST_COUNT];

  logic [LIST_COUNT-1:0] we;
  value_t                wval;
  value_t                rdata [LIST_COUNT];
  head_t [LIST_COUNT-1:0] heads;
  win_t                  win;

  // result register
  logic                        done_q;
  logic                        done_d;
  status_e                     status_q;
  status_e                     status_d;
  logic signed [DATA_BITS-1:0] mval_q;
  logic signed [DATA_BITS-1:0] mval_d;
  logic [IDX_BITS-1:0]         src_q;
  logic [IDX_BITS-1:0]         src_d;

  logic idx_ok;
  logic any_head;

  assign busy_o = 1'b0;

  // take the item into the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      kind_q <= kind_e'(kind_i);
      idx_q  <= list_index_i;
      val_q  <= element_value_i;
    end
  end

  // cut or sign-extend the loaded value to the stored width
  assign wval   = value_t'(val_q);
  assign idx_ok = int'(idx_q) < LIST_COUNT;

  // list heads: bypass right after a load into an empty list, else ram output
  always_comb begin
    any_head = 1'b0;
    for (int l = 0; l < LIST_COUNT; l++) begin
      heads[l].valid = (cnt_q[l] != '0);
      heads[l].value = byp_sel_q[l] ? byp_q[l] : rdata[l];
      any_head       = any_head || heads[l].valid;
    end
  end

  kwm_min_tree u_tree (
    .heads_i (heads),
    .win_o   (win)
  );

  // next state and result
  always_comb begin
    done_d    = in_v_q;
    status_d  = ST_LOADED;
    mval_d    = '0;
    src_d     = '0;
    we        = '0;
    byp_sel_d = '0;
    for (int l = 0; l < LIST_COUNT; l++) begin
      rd_ptr_d[l] = rd_ptr_q[l];
      wr_ptr_d[l] = wr_ptr_q[l];
      cnt_d[l]    = cnt_q[l];
    end

    if (in_v_q) begin
      unique case (kind_q)
        KIND_LOAD: begin
          status_d = ST_DROPPED;
          for (int l = 0; l < LIST_COUNT; l++) begin
            if (idx_ok && (int'(idx_q) == l) && (cnt_q[l] != CNT_BITS'(LIST_DEPTH))) begin
              we[l]        = 1'b1;
              byp_sel_d[l] = (cnt_q[l] == '0);
              wr_ptr_d[l]  = (wr_ptr_q[l] == PTR_BITS'(LIST_DEPTH - 1)) ? '0
                                                                         : wr_ptr_q[l] + 1'b1;
              cnt_d[l]     = cnt_q[l] + 1'b1;
              status_d     = ST_LOADED;
            end
          end
        end
        KIND_PULL: begin
          if (win.found) begin
            status_d = ST_MERGED;
            mval_d   = DATA_BITS'(win.value);
            src_d    = IDX_BITS'(win.idx);
            for (int l = 0; l < LIST_COUNT; l++) begin
              if (int'(win.idx) == l) begin
                rd_ptr_d[l] = (rd_ptr_q[l] == PTR_BITS'(LIST_DEPTH - 1)) ? '0
                                                                          : rd_ptr_q[l] + 1'b1;
                cnt_d[l]    = cnt_q[l] - 1'b1;
              end
            end
          end else begin
            status_d = ST_EMPTY;
          end
        end
        default: begin
          status_d = ST_EMPTY;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q    <= 1'b0;
      byp_sel_q <= '0;
      for (int l = 0; l < LIST_COUNT; l++) begin
        rd_ptr_q[l] <= '0;
        wr_ptr_q[l] <= '0;
        cnt_q[l]    <= '0;
      end
    end else begin
      done_q    <= done_d;
      byp_sel_q <= byp_sel_d;
      for (int l = 0; l < LIST_COUNT; l++) begin
        rd_ptr_q[l] <= rd_ptr_d[l];
        wr_ptr_q[l] <= wr_ptr_d[l];
        cnt_q[l]    <= cnt_d[l];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    mval_q   <= mval_d;
    src_q    <= src_d;
    for (int l = 0; l < LIST_COUNT; l++) begin
      if (byp_sel_d[l]) begin
        byp_q[l] <= wval;
      end
    end
  end

  // list bodies: each ram reads at the next read pointer every cycle
  for (genvar g = 0; g < LIST_COUNT; g++) begin : g_list
    kwm_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (LIST_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (we[g]),
      .waddr_i (wr_ptr_q[g]),
      .wdata_i (wval),
      .raddr_i (rd_ptr_d[g]),
      .rdata_o (rdata[g])
    );
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign merged_value_o = mval_q;
  assign source_list_o  = src_q;

`ifndef ASSERT_OFF
  // every item in the input register gives exactly one result next cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(in_v_q))
    else $error("result strobe does not follow the input register");

  // a pull with every list empty reports empty
  a_empty_pull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_v_q && (kind_q == KIND_PULL) && !any_head) |=> (status_o == ST_EMPTY))
    else $error("pull on empty lists did not report empty");

  // at most one list body is written per cycle
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(we))
    else $error("more than one list written in a cycle");

  // the tree finds a winner exactly when some list holds a value
  a_tree_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win.found == any_head)
    else $error("compare tree winner disagrees with list fill state");
`endif

endmodule

[rtl/core/kwm_ram.sv]
// kwm_ram: generic single write port, single read port ram with registered read
// no dependencies; used for the body of each list
`timescale 1ns / 1ps

module kwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/kwm_min_tree.sv]
// kwm_min_tree: combinational compare tree picking the smallest valid list head
// depends on kwm_pkg
`timescale 1ns / 1ps

module kwm_min_tree import kwm_pkg::*; (
  input  head_t [LIST_COUNT-1:0] heads_i,
  output win_t                   win_o
);

  localparam int TREE_N = 1 << LIST_BITS;

  head_t node_h [1:2*TREE_N-1];
  lidx_t node_i [1:2*TREE_N-1];

  always_comb begin
    logic take_left;
    take_left = 1'b0;
    for (int i = 0; i < TREE_N; i++) begin
      node_h[TREE_N+i] = (i < LIST_COUNT) ? heads_i[i] : '0;
      node_i[TREE_N+i] = LIST_BITS'(i);
    end
    // left child has the lower list number, so it wins ties
    for (int i = TREE_N - 1; i >= 1; i--) begin
      take_left = node_h[2*i].valid &&
                  (!node_h[2*i+1].valid ||
                   ($signed(node_h[2*i].value) <= $signed(node_h[2*i+1].value)));
      node_h[i] = take_left ? node_h[2*i] : node_h[2*i+1];
      node_i[i] = take_left ? node_i[2*i] : node_i[2*i+1];
    end
  end

  assign win_o.found = node_h[1].valid;
  assign win_o.idx   = node_i[1];
  assign win_o.value = node_h[1].value;

endmodule
